// File: rtl/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO     = 2'd1;
   localparam logic [1:0] ST_NOMEM    = 2'd2;
   localparam logic [1:0] ST_BADFREE  = 2'd3;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_RD,
      S_EV,
      S_NEV,
      S_MG,
      S_SHD_RD,
      S_SHD_WR,
      S_SHU_RD,
      S_SHU_WR,
      S_SPL1,
      S_SPL0,
      S_RESP
   } walk_state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_address;
      logic [16:0] bytes_in_use;
   } result_type;

endpackage

// File: rtl/ffha_seg_ram.sv
// Segment table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ffha_seg_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/ffha_walker.sv
// Table walker: scans, splits, marks and merges segments through the table memory.
`timescale 1ns / 1ps
module ffha_walker import ffha_pkg::*; #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 12,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] heap_base,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [16:0] req_bytes,
   input  logic [31:0] req_address,
   output logic        res_valid,
   input  logic        res_ready,
   output result_type  res
);
   localparam int IDX_W  = $clog2(MAX_SEGMENTS);
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int SEG_W  = $clog2(HEAP_BYTES);
   localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
   localparam int RQ_W   = 18;
   localparam int CW     = ((SEG_W > RQ_W) ? SEG_W : RQ_W) + 3;
   localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] FOUR = CW'(4);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

   walk_state_type state_ff, state_in;

   logic              op_ff, op_in;
   logic [RQ_W-1:0]   req_ff, req_in;
   logic [31:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  sh_ff, sh_in;
   logic [1:0]        rem_ff, rem_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [OFF_W-1:0]  used_ff, used_in;
   logic              pfree_ff, pfree_in;
   logic [SEG_W-1:0]  pbytes_ff, pbytes_in;
   logic [SEG_W-1:0]  hit_ff, hit_in;
   logic              nfree_ff, nfree_in;
   logic [SEG_W-1:0]  nbytes_ff, nbytes_in;
   logic [1:0]        stat_ff, stat_in;
   logic [31:0]       daddr_ff, daddr_in;

   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [SEG_W:0]    rd_data, wr_data;
   logic              d_free;
   logic [SEG_W-1:0]  d_bytes;
   logic [31:0]       seg_addr;
   logic [CW-1:0]     next_off, rnd, newb;
   logic [CNT_W-1:0]  tgt, src;
   logic [OFF_W+16:0] used_ext;

   ffha_seg_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH(SEG_W + 1)) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign d_free   = rd_data[SEG_W];
   assign d_bytes  = rd_data[SEG_W-1:0];
   assign seg_addr = heap_base + 32'(off_ff) + 32'(HEADER_BYTES);
   assign next_off = CW'(off_ff) + HDR + CW'(d_bytes);
   assign src      = sh_ff + CNT_W'(rem_ff);
   assign used_ext = {17'b0, used_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= ONE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         used_ff  <= used_in;
      end
      op_ff     <= op_in;
      req_ff    <= req_in;
      addr_ff   <= addr_in;
      idx_ff    <= idx_in;
      sh_ff     <= sh_in;
      rem_ff    <= rem_in;
      off_ff    <= off_in;
      pfree_ff  <= pfree_in;
      pbytes_ff <= pbytes_in;
      hit_ff    <= hit_in;
      nfree_ff  <= nfree_in;
      nbytes_ff <= nbytes_in;
      stat_ff   <= stat_in;
      daddr_ff  <= daddr_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      req_in    = req_ff;
      addr_in   = addr_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      sh_in     = sh_ff;
      rem_in    = rem_ff;
      off_in    = off_ff;
      used_in   = used_ff;
      pfree_in  = pfree_ff;
      pbytes_in = pbytes_ff;
      hit_in    = hit_ff;
      nfree_in  = nfree_ff;
      nbytes_in = nbytes_ff;
      stat_in   = stat_ff;
      daddr_in  = daddr_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[IDX_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[IDX_W-1:0];
      wr_data   = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;
      rnd       = '0;
      newb      = '0;
      tgt       = idx_ff;
      res.status       = stat_ff;
      res.data_address = daddr_ff;
      res.bytes_in_use = used_ext[16:0];

      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {1'b1, SEG_W'(HEAP_BYTES - HEADER_BYTES)};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rnd       = (CW'(req_bytes) + CW'(3)) & ~CW'(3);
               op_in     = req_opcode;
               req_in    = rnd[RQ_W-1:0];
               addr_in   = req_address;
               idx_in    = '0;
               off_in    = '0;
               pfree_in  = 1'b0;
               daddr_in  = '0;
               stat_in   = ST_OK;
               state_in  = S_RD;
               if (req_opcode == OP_ALLOC && req_bytes == '0) begin
                  stat_in  = ST_ZERO;
                  state_in = S_RESP;
               end else if (req_opcode == OP_FREE && req_address == '0) begin
                  state_in = S_RESP;
               end
            end
         end
         S_RD: begin
            if (idx_ff == cnt_ff) begin
               stat_in  = (op_ff == OP_ALLOC) ? ST_NOMEM : ST_BADFREE;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               state_in = S_EV;
            end
         end
         S_EV: begin
            // advance past this segment unless it is the one we want
            off_in    = next_off[OFF_W-1:0];
            pfree_in  = d_free;
            pbytes_in = d_bytes;
            idx_in    = idx_ff + ONE;
            state_in  = S_RD;
            hit_in    = d_bytes;
            if (op_ff == OP_ALLOC) begin
               if (d_free && CW'(d_bytes) >= CW'(req_ff)) begin
                  idx_in   = idx_ff;
                  off_in   = off_ff;
                  pfree_in = pfree_ff;
                  pbytes_in = pbytes_ff;
                  daddr_in = seg_addr;
                  if (CW'(d_bytes) > CW'(req_ff) + HDR + FOUR && cnt_ff < CNT_MAX) begin
                     used_in  = used_ff + OFF_W'(req_ff);
                     sh_in    = cnt_ff;
                     state_in = S_SHU_RD;
                  end else begin
                     used_in  = used_ff + OFF_W'(d_bytes);
                     wr_en    = 1'b1;
                     wr_data  = {1'b0, d_bytes};
                     state_in = S_RESP;
                  end
               end
            end else if (seg_addr == addr_ff) begin
               idx_in    = idx_ff;
               off_in    = off_ff;
               pfree_in  = pfree_ff;
               pbytes_in = pbytes_ff;
               if (d_free) begin
                  stat_in  = ST_BADFREE;
                  state_in = S_RESP;
               end else begin
                  used_in = used_ff - OFF_W'(d_bytes);
                  if (idx_ff + ONE < cnt_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_in[IDX_W-1:0] + IDX_W'(1);
                     state_in = S_NEV;
                  end else begin
                     nfree_in = 1'b0;
                     state_in = S_MG;
                  end
               end
            end
         end
         S_NEV: begin
            nfree_in  = d_free;
            nbytes_in = d_bytes;
            state_in  = S_MG;
         end
         S_MG: begin
            // fold the neighbors into one free segment, then close the gap
            tgt  = pfree_ff ? idx_ff - ONE : idx_ff;
            newb = CW'(hit_ff) + (pfree_ff ? CW'(pbytes_ff) + HDR : '0)
                   + (nfree_ff ? CW'(nbytes_ff) + HDR : '0);
            wr_en   = 1'b1;
            wr_addr = tgt[IDX_W-1:0];
            wr_data = {1'b1, newb[SEG_W-1:0]};
            rem_in  = {1'b0, pfree_ff} + {1'b0, nfree_ff};
            sh_in   = tgt + ONE;
            state_in = (pfree_ff || nfree_ff) ? S_SHD_RD : S_RESP;
         end
         S_SHD_RD: begin
            if (src >= cnt_ff) begin
               cnt_in   = cnt_ff - CNT_W'(rem_ff);
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = src[IDX_W-1:0];
               state_in = S_SHD_WR;
            end
         end
         S_SHD_WR: begin
            wr_en    = 1'b1;
            wr_addr  = sh_ff[IDX_W-1:0];
            wr_data  = rd_data;
            sh_in    = sh_ff + ONE;
            state_in = S_SHD_RD;
         end
         S_SHU_RD: begin
            if (sh_ff == idx_ff + ONE) begin
               state_in = S_SPL1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = sh_ff[IDX_W-1:0] - IDX_W'(1);
               state_in = S_SHU_WR;
            end
         end
         S_SHU_WR: begin
            wr_en    = 1'b1;
            wr_addr  = sh_ff[IDX_W-1:0];
            wr_data  = rd_data;
            sh_in    = sh_ff - ONE;
            state_in = S_SHU_RD;
         end
         S_SPL1: begin
            newb     = CW'(hit_ff) - CW'(req_ff) - HDR;
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0] + IDX_W'(1);
            wr_data  = {1'b1, newb[SEG_W-1:0]};
            state_in = S_SPL0;
         end
         S_SPL0: begin
            wr_en    = 1'b1;
            wr_data  = {1'b0, SEG_W'(req_ff)};
            cnt_in   = cnt_ff + ONE;
            state_in = S_RESP;
         end
         S_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// File: rtl/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: ports, base register, result register.
`timescale 1ns / 1ps
// Usage:
//   req_*  carries one allocate (req_tuser = 0) or free (req_tuser = 1) item.
//   rsp_*  returns exactly one result item per request: status, data address,
//          bytes in use after the request.
//   csr_*  writes heap_base; write it only while no request is in flight.
// Walk: a request walks the segment table one entry at a time, a read state
//   and an evaluate state per entry, through the single read port of the table
//   memory, then shifts the table by one or two places (a read and a write per
//   moved entry) on a split or a merge. A zero-size allocation or a null free
//   skips the walk; one request is handled at a time. Its result item is
//   registered in the output register before it shows on rsp_*.
// Reset: the table is loaded with one free segment in the init state after
//   reset, during which req_tready stays low; heap_base returns to 1048576.
// Stall: a finished result sits in the output register until rsp_tready; the
//   next request is accepted meanwhile but its result waits for the register.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
   parameter int HEAP_BYTES   = 65536,
   parameter int HEADER_BYTES = 12,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // request_bytes[16:0], free_address[48:17], zero pad
   input  logic [0:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status[1:0], data_address[33:2], bytes_in_use[50:34]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   logic [31:0] base_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        res_valid, res_ready;
   result_type  res;

   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 32'd1048576;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            base_ff <= csr_data;
         end
         if (res_ready) begin
            rsp_valid_ff <= res_valid;
         end
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   ffha_walker #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .heap_base   (base_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser[0]),
      .req_bytes   (req_tdata[16:0]),
      .req_address (req_tdata[48:17]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.bytes_in_use, rsp_ff.data_address, rsp_ff.status};
endmodule

// File: sim/first_fit_heap_allocator_core_tb.sv
// Self-checking testbench for the first-fit heap allocator core.
`timescale 1ns / 1ps
module first_fit_heap_allocator_core_tb;
   import ffha_pkg::*;

   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 12;
   localparam int MAX_SEGMENTS = 64;
   localparam int DRAIN_CYCLES = 4 * MAX_SEGMENTS + 40;

   typedef struct {
      logic        opcode;
      logic [16:0] req_bytes;
      logic [31:0] addr;
      logic        cfg;       // base write marker, not a request
      logic [31:0] cfg_value;
      logic        hold;      // pause until every result has come
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   first_fit_heap_allocator_core #(
      .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES), .MAX_SEGMENTS(MAX_SEGMENTS)
   ) dut (.*);

   always #4 clock = ~clock;

   // allocator image
   logic [31:0] base_reg;
   int unsigned seg_bytes [MAX_SEGMENTS];
   bit          seg_free [MAX_SEGMENTS];
   int unsigned seg_count;
   int unsigned used_bytes;
   logic [31:0] live_addrs[$];

   result_type  expected_results[$];
   request_type pending_items[$];
   int          error_count = 0;
   bit          stim_done = 1'b0;
   bit          rsp_hold_off = 1'b0;
   bit          calm = 1'b0;

   function automatic logic [31:0] seg_addr(int unsigned offset);
      return base_reg + offset + HEADER_BYTES;
   endfunction

   function automatic void merge_free();
      int unsigned i;
      i = 0;
      while (i + 1 < seg_count) begin
         if (seg_free[i] && seg_free[i+1]) begin
            seg_bytes[i] += HEADER_BYTES + seg_bytes[i+1];
            for (int unsigned k = i + 1; k + 1 < seg_count; k++) begin
               seg_bytes[k] = seg_bytes[k+1];
               seg_free[k] = seg_free[k+1];
            end
            seg_count--;
            seg_bytes[seg_count] = 0;
            seg_free[seg_count] = 1'b0;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic result_type predict_heap(request_type it);
      result_type r;
      int unsigned offset, need;
      bit done;
      r.status = ST_OK;
      r.data_address = '0;
      offset = 0;
      done = 1'b0;
      if (it.opcode == OP_ALLOC) begin
         if (it.req_bytes == 0) begin
            r.status = ST_ZERO;
         end else begin
            need = (int'(it.req_bytes) + 3) & ~3;
            for (int unsigned i = 0; i < seg_count && !done; i++) begin
               if (seg_free[i] && seg_bytes[i] >= need) begin
                  if (seg_bytes[i] > need + HEADER_BYTES + 4 && seg_count < MAX_SEGMENTS) begin
                     for (int unsigned k = seg_count; k > i + 1; k--) begin
                        seg_bytes[k] = seg_bytes[k-1];
                        seg_free[k] = seg_free[k-1];
                     end
                     seg_bytes[i+1] = seg_bytes[i] - need - HEADER_BYTES;
                     seg_free[i+1] = 1'b1;
                     seg_bytes[i] = need;
                     seg_count++;
                  end
                  seg_free[i] = 1'b0;
                  used_bytes += seg_bytes[i];
                  r.data_address = seg_addr(offset);
                  live_addrs.push_back(r.data_address);
                  done = 1'b1;
               end
               offset += HEADER_BYTES + seg_bytes[i];
            end
            if (!done) r.status = ST_NOMEM;
         end
      end else if (it.addr != 0) begin
         for (int unsigned i = 0; i < seg_count && !done; i++) begin
            if (seg_addr(offset) == it.addr) begin
               if (!seg_free[i]) begin
                  seg_free[i] = 1'b1;
                  used_bytes -= seg_bytes[i];
                  merge_free();
                  done = 1'b1;
               end else begin
                  i = seg_count;
               end
            end
            offset += HEADER_BYTES + seg_bytes[i < seg_count ? i : 0];
         end
         if (!done) r.status = ST_BADFREE;
      end
      r.bytes_in_use = used_bytes[16:0];
      return r;
   endfunction

   function automatic request_type mk_alloc(int unsigned n);
      request_type it;
      it = '{OP_ALLOC, n[16:0], $urandom, 1'b0, 32'd0, 1'b0};
      return it;
   endfunction

   function automatic request_type mk_free(logic [31:0] a);
      request_type it;
      it = '{OP_FREE, 17'($urandom), a, 1'b0, 32'd0, 1'b0};
      return it;
   endfunction

   function automatic request_type mk_cfg(logic [31:0] v);
      request_type it;
      it = '{OP_ALLOC, '0, '0, 1'b1, v, 1'b1};
      return it;
   endfunction

   // Addresses for the list-pick frees are drawn from the live list kept by the predictor.
   // The list may hold stale entries; those give bad-free cases or free a later grant at the same address.
   initial begin
      request_type it;
      int unsigned n;
      logic [31:0] a;
      // directed part
      pending_items.push_back(mk_alloc(0));
      pending_items.push_back(mk_alloc(1));
      pending_items.push_back(mk_alloc(65536));
      pending_items.push_back(mk_alloc(131071));
      pending_items.push_back(mk_alloc(HEAP_BYTES - HEADER_BYTES));
      pending_items.push_back(mk_free(32'd1048576 + HEADER_BYTES));
      pending_items.push_back(mk_free(32'd1048576 + HEADER_BYTES));
      pending_items.push_back(mk_free(32'd0));
      pending_items.push_back(mk_free(32'hFFFF_FFFF));
      pending_items.push_back(mk_alloc(5));
      pending_items.push_back(mk_alloc(HEAP_BYTES - 2 * HEADER_BYTES - 8));
      pending_items.push_back(mk_free(32'd1048576 + HEADER_BYTES + 4));
      pending_items.push_back(mk_free(32'd1048576 + HEADER_BYTES));
      pending_items.push_back(mk_free(32'd1048576 + 2 * HEADER_BYTES + 8));
      pending_items.push_back(mk_cfg(32'hFFFF_FFF8));
      pending_items.push_back(mk_alloc(8));
      pending_items.push_back(mk_alloc(8));
      pending_items.push_back(mk_free(32'hFFFF_FFF8 + HEADER_BYTES));
      // fill the table so later allocations go unsplit
      for (int i = 0; i < 70; i++) pending_items.push_back(mk_alloc(4));
      pending_items.push_back(mk_alloc(60000));
      pending_items.push_back(mk_cfg(32'd0));
      for (int i = 0; i < 80; i++) pending_items.push_back(mk_free(HEADER_BYTES + 16 * i));
      pending_items.push_back(mk_cfg(32'd1048576));
      // random part: mostly frees, most of them of addresses picked from the live list
      for (int i = 0; i < 2000; i++) begin
         if (i == 700) pending_items.push_back(mk_cfg($urandom));
         if (i == 1400) pending_items.push_back(mk_cfg(32'd1048576));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(1, 2048);
               pending_items.push_back(mk_alloc(n));
            end
            4, 5, 6, 7, 8: begin
               it = mk_free(32'd0);
               it.hold = 1'b0;
               it.addr = 32'hDEAD_0000; // resolved at drive time
               it.cfg_value = 32'd1;    // marks a pick from the live list
               pending_items.push_back(it);
            end
            default: begin
               a = ($urandom_range(0, 1)) ? $urandom : 32'd1048576 + $urandom_range(0, 65535);
               pending_items.push_back(mk_free(a));
            end
         endcase
         if (i == 1000) begin
            it = mk_free(32'd0);
            it.hold = 1'b1;
            pending_items.push_back(it);
         end
      end
   end

   int unsigned rsp_stall;

   // driver
   always @(posedge clock) begin
      request_type it;
      int unsigned idx;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
      end else if (csr_valid) begin
         if (csr_ready) begin
            csr_valid <= 1'b0;
            base_reg = csr_data;
         end
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            it.opcode = req_tuser[0];
            it.req_bytes = req_tdata[16:0];
            it.addr = req_tdata[48:17];
            expected_results.push_back(predict_heap(it));
         end
         if (pending_items.size() == 0) begin
            req_tvalid <= 1'b0;
            stim_done <= 1'b1;
         end else if (pending_items[0].hold && expected_results.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_items[0].cfg) begin
            req_tvalid <= 1'b0;
            if (rsp_stall == 0) rsp_stall = DRAIN_CYCLES;
            else if (rsp_stall == 1) begin
               rsp_stall = 0;
               it = pending_items.pop_front();
               csr_data <= it.cfg_value;
               csr_valid <= 1'b1;
            end else rsp_stall--;
         end else if (!calm && $urandom_range(0, 99) < 32) begin
            req_tvalid <= 1'b0;
         end else begin
            it = pending_items.pop_front();
            if (it.opcode == OP_FREE && it.addr == 32'hDEAD_0000 && it.cfg_value == 1) begin
               if (live_addrs.size() == 0) it.addr = 32'd0;
               else begin
                  idx = $urandom_range(0, live_addrs.size() - 1);
                  it.addr = live_addrs[idx];
                  live_addrs.delete(idx);
               end
            end
            req_tdata <= {7'd0, it.addr, it.req_bytes};
            req_tuser <= it.opcode;
            req_tvalid <= 1'b1;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      result_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[1:0];
         got.data_address = rsp_tdata[33:2];
         got.bytes_in_use = rsp_tdata[50:34];
         if (expected_results.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            error_count++;
         end else begin
            exp = expected_results.pop_front();
            if (got.status !== exp.status) begin
               $error("status: expected %0d actual %0d", exp.status, got.status);
               error_count++;
            end
            if (got.data_address !== exp.data_address) begin
               $error("data_address: expected %h actual %h", exp.data_address,
                      got.data_address);
               error_count++;
            end
            if (got.bytes_in_use !== exp.bytes_in_use) begin
               $error("bytes_in_use: expected %0d actual %0d", exp.bytes_in_use,
                      got.bytes_in_use);
               error_count++;
            end
         end
      end
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= rsp_hold_off ? 1'b0 : (calm || $urandom_range(0, 99) >= 32);
   end

   // image setup, reset release, receiver hold-off and calm stretch, timed in cycles
   initial begin
      base_reg = 32'd1048576;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         seg_bytes[i] = 0;
         seg_free[i] = 1'b0;
      end
      seg_bytes[0] = HEAP_BYTES - HEADER_BYTES;
      seg_free[0] = 1'b1;
      seg_count = 1;
      used_bytes = 0;
      rsp_stall = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (3000) @(posedge clock);
      rsp_hold_off <= 1'b1;
      repeat (2000) @(posedge clock);
      rsp_hold_off <= 1'b0;
      repeat (20000) @(posedge clock);
      calm <= 1'b1;
      repeat (20000) @(posedge clock);
      calm <= 1'b0;
   end

   initial begin
      wait (stim_done && !req_tvalid);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ffha_pkg.sv
rtl/ffha_seg_ram.sv
rtl/ffha_walker.sv
rtl/first_fit_heap_allocator_core.sv
sim/first_fit_heap_allocator_core_tb.sv
